[src/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared codes, result field widths and the controller/datapath command and
// status types.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  // Result field widths.
  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 30;

  // Operation codes.
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // Order codes for a against b.
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Product selects for the shared multiplier.
  localparam logic [1:0] MUL_P1 = 2'd0;
  localparam logic [1:0] MUL_P2 = 2'd1;
  localparam logic [1:0] MUL_P3 = 2'd2;
  localparam logic [1:0] MUL_P4 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       form;
    logic       mag;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } rau_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic gcd_done;
    logic div_last;
  } rau_sts_t;

endpackage

`default_nettype wire

[src/rau_in_if.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit input channel
// Valid/ready channel carrying the action and the two operand fractions.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_in_if #(
  parameter int OPERAND_WIDTH = 16
) ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic [OPERAND_WIDTH-2:0]   a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic [OPERAND_WIDTH-2:0]   b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

`default_nettype wire

[src/rau_out_if.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit result channel
// Valid/ready channel carrying the reduced fraction, the error flag and order.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_out_if import rau_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;
  logic                        div_zero;
  logic [1:0]                  order;

  modport source (output valid, res_num, res_den, div_zero, order, input ready);
  modport sink   (input valid, res_num, res_den, div_zero, order, output ready);
endinterface

`default_nettype wire

[src/rational_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit core
// Adds, subtracts, multiplies or divides two fractions and returns the result
// in lowest terms with a positive denominator, plus the order of a against b.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                   Handshake
//   in_ch     in    action, a_num, a_den, b_num, b_den        valid/ready
//   out_ch    out   res_num, res_den, div_zero, order         valid/ready
//
// One word at a time. An accepted word passes through the four multiplies,
// forming, magnitude, the binary GCD loop and the bit-serial divider to the
// result register; a zero result skips GCD and divide.
// Reset (synchronous, active low) empties the result register and idles.
// A new word is taken while a finished result waits; a stalled sink holds
// the next result in the controller's final state.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  rau_cmd_t cmd;
  rau_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // Sequencing and handshakes.
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and reduction.
  rau_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_ch.action),
    .in_a_num     (in_ch.a_num),
    .in_a_den     (in_ch.a_den),
    .in_b_num     (in_ch.b_num),
    .in_b_den     (in_ch.b_den),
    .out_res_num  (out_ch.res_num),
    .out_res_den  (out_ch.res_den),
    .out_div_zero (out_ch.div_zero),
    .out_order    (out_ch.order)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

[src/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences one word through multiply, form, magnitude, GCD and divide steps
// and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl import rau_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire rau_sts_t sts,
  output rau_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_MUL2 = 4'd2;
  localparam logic [3:0] ST_MUL3 = 4'd3;
  localparam logic [3:0] ST_FORM = 4'd4;
  localparam logic [3:0] ST_MAG  = 4'd5;
  localparam logic [3:0] ST_GCD  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;
  localparam logic [3:0] ST_MUL4 = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_P1;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P2;
        state_nxt   = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P3;
        state_nxt   = ST_MUL4;
      end
      ST_MUL4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P4;
        state_nxt   = ST_FORM;
      end
      ST_FORM: begin
        cmd.form  = 1'b1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = sts.n_zero ? ST_DONE : ST_GCD;
      end
      ST_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result register stays full until the sink takes it.
  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[src/rau_datapath.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Shared multiplier, numerator/denominator forming, binary GCD and a dual
// restoring divider that reduces the fraction by the GCD.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire rau_cmd_t                         cmd,
  output rau_sts_t                              sts,
  input  wire logic [1:0]                       in_action,
  input  wire logic signed [OPERAND_WIDTH-1:0]  in_a_num,
  input  wire logic [OPERAND_WIDTH-2:0]         in_a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0]  in_b_num,
  input  wire logic [OPERAND_WIDTH-2:0]         in_b_den,
  output logic signed [RES_NUM_W-1:0]           out_res_num,
  output logic [RES_DEN_W-1:0]                  out_res_den,
  output logic                                  out_div_zero,
  output logic [1:0]                            out_order
);

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = 2 * W;
  localparam int CW = $clog2(NW);
  localparam int XW = (NW > RES_NUM_W) ? NW : RES_NUM_W;
  localparam int XD = (NW > RES_DEN_W) ? NW : RES_DEN_W;

  // Operand registers.
  logic [1:0]          act_r;
  logic signed [W-1:0] an_r, bn_r;
  logic [W-2:0]        ad_r, bd_r;

  // Products, formed fraction and flags.
  logic signed [NW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [NW-1:0] n_r, d_r;
  logic                 dz_r, neg_r;
  logic [1:0]           ord_r;

  // GCD and divider registers.
  logic [NW-1:0] x_r, y_r, qn_r, qd_r, remn_r, remd_r;
  logic [CW-1:0] cnt_r;

  // Result registers.
  logic signed [RES_NUM_W-1:0] res_num_r;
  logic [RES_DEN_W-1:0]        res_den_r;
  logic                        res_dz_r;
  logic [1:0]                  res_ord_r;

  // Capture the operands; a zero denominator counts as one.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      an_r  <= in_a_num;
      bn_r  <= in_b_num;
      ad_r  <= (in_a_den == '0) ? (W-1)'(1) : in_a_den;
      bd_r  <= (in_b_den == '0) ? (W-1)'(1) : in_b_den;
    end
  end

  // Shared signed multiplier, one product per cycle. The third product is
  // the numerator product and the fourth the denominator product.
  logic signed [W-1:0]  opa, opb;
  logic signed [NW-1:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      MUL_P1: begin
        opa = an_r;
        opb = $signed({1'b0, bd_r});
      end
      MUL_P2: begin
        opa = bn_r;
        opb = $signed({1'b0, ad_r});
      end
      MUL_P3: begin
        opa = an_r;
        opb = bn_r;
      end
      default: begin
        opa = $signed({1'b0, ad_r});
        opb = $signed({1'b0, bd_r});
      end
    endcase
    prod = opa * opb;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_P1:  p1_r <= prod;
        MUL_P2:  p2_r <= prod;
        MUL_P3:  p3_r <= prod;
        default: p4_r <= prod;
      endcase
    end
  end

  // Form the unreduced numerator and denominator and the order of a and b.
  logic signed [NW-1:0] diff, sum, n_form, d_form;
  logic                 dz_form;
  logic [1:0]           ord_form;

  always_comb begin
    diff    = p1_r - p2_r;
    sum     = p1_r + p2_r;
    dz_form = (act_r == ACT_DIV) && (bn_r == '0);
    case (act_r)
      ACT_ADD: begin
        n_form = sum;
        d_form = p4_r;
      end
      ACT_SUB: begin
        n_form = diff;
        d_form = p4_r;
      end
      ACT_MUL: begin
        n_form = p3_r;
        d_form = p4_r;
      end
      default: begin
        n_form = dz_form ? '0 : p1_r;
        d_form = dz_form ? NW'(1) : p2_r;
      end
    endcase
    if (diff[NW-1]) begin
      ord_form = ORD_LT;
    end else if (diff == '0) begin
      ord_form = ORD_EQ;
    end else begin
      ord_form = ORD_GT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      n_r   <= n_form;
      d_r   <= d_form;
      dz_r  <= dz_form;
      ord_r <= ord_form;
    end
  end

  // Magnitudes and result sign.
  logic [NW-1:0] nm, dm;
  logic          n_zero;

  assign n_zero = (n_r == '0);
  assign nm     = n_r[NW-1] ? (~n_r + 1'b1) : n_r;
  assign dm     = d_r[NW-1] ? (~d_r + 1'b1) : d_r;

  // Binary GCD step terms.
  logic [NW:0]   xy_sub;
  logic [NW-1:0] yx_sub;

  assign xy_sub = {1'b0, x_r} - {1'b0, y_r};
  assign yx_sub = y_r - x_r;

  // Divider step terms: both quotients share the odd GCD part as divisor.
  logic [NW:0] tn, td;
  logic        qbit_n, qbit_d;

  assign tn     = {remn_r, qn_r[NW-1]};
  assign td     = {remd_r, qd_r[NW-1]};
  assign qbit_n = (tn >= {1'b0, x_r});
  assign qbit_d = (td >= {1'b0, x_r});

  // GCD and divide registers. Common factors of two are stripped from the
  // dividends during the GCD, so the divisor is the remaining odd part.
  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      neg_r <= (n_r[NW-1] != d_r[NW-1]) && !n_zero;
      x_r   <= nm;
      y_r   <= dm;
      if (n_zero) begin
        qn_r <= '0;
        qd_r <= NW'(1);
      end else begin
        qn_r <= nm;
        qd_r <= dm;
      end
    end else if (cmd.gcd_step) begin
      if (!x_r[0] && !y_r[0]) begin
        x_r  <= x_r >> 1;
        y_r  <= y_r >> 1;
        qn_r <= qn_r >> 1;
        qd_r <= qd_r >> 1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (!xy_sub[NW]) begin
        x_r <= xy_sub[NW-1:0];
      end else begin
        y_r <= yx_sub;
      end
    end else if (cmd.div_init) begin
      remn_r <= '0;
      remd_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      remn_r <= qbit_n ? NW'(tn - {1'b0, x_r}) : tn[NW-1:0];
      remd_r <= qbit_d ? NW'(td - {1'b0, x_r}) : td[NW-1:0];
      qn_r   <= {qn_r[NW-2:0], qbit_n};
      qd_r   <= {qd_r[NW-2:0], qbit_d};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // Signed result, sized to the output fields.
  logic [NW-1:0] rn;
  logic [XW-1:0] rn_ext;
  logic [XD-1:0] rd_ext;

  assign rn     = neg_r ? (~qn_r + 1'b1) : qn_r;
  assign rn_ext = XW'($signed(rn));
  assign rd_ext = XD'(qd_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num_r <= $signed(rn_ext[RES_NUM_W-1:0]);
      res_den_r <= rd_ext[RES_DEN_W-1:0];
      res_dz_r  <= dz_r;
      res_ord_r <= ord_r;
    end
  end

  assign sts.n_zero   = n_zero;
  assign sts.gcd_done = (x_r == y_r);
  assign sts.div_last = (cnt_r == CW'(NW - 1));

  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_div_zero = res_dz_r;
  assign out_order    = res_ord_r;

endmodule

`default_nettype wire
